// File: rtl/core/assert_macros.svh
// Shared assertion macros. Each expects signals named clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dbpm_pkg.sv
package dbpm_pkg;

	localparam int SYM_W     = 8;
	localparam int POS_OUT_W = 10;
	localparam int KIND_W    = 3;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int TYPES_W   = 3;
	localparam int CHAR_SLOTS = 4;
	localparam int QDEPTH    = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAIR      = 3'd0,
		KIND_VALID     = 3'd1,
		KIND_ILLEGAL   = 3'd2,
		KIND_UNMATCHED = 3'd3,
		KIND_UNCLOSED  = 3'd4,
		KIND_OVERFLOW  = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPEN     = 3'd0,
		CFG_CLOSE    = 3'd1,
		CFG_TYPES    = 3'd2,
		CFG_UNPAIRED = 3'd3,
		CFG_BREAK    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]   open_chars;
		logic [CFG_W-1:0]   close_chars;
		logic [TYPES_W-1:0] types_used;
		logic [CFG_W-1:0]   unpaired_chars;
		logic [CFG_W-1:0]   break_chars;
	} cfg_t;

	typedef struct packed {
		logic                 has_pair;
		logic [POS_OUT_W-1:0] close_pos;
		logic                 has_status;
		kind_t                status;
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [POS_OUT_W-1:0] open_pos;
	} entry_t;

endpackage

// File: rtl/core/dbpm_if.sv
interface dbpm_char_if;
	logic                       valid;
	logic                       ready;
	logic [dbpm_pkg::SYM_W-1:0] symbol;
	logic                       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface dbpm_res_if;
	logic                           valid;
	logic                           ready;
	logic [dbpm_pkg::KIND_W-1:0]    kind;
	logic [dbpm_pkg::POS_OUT_W-1:0] open_pos;
	logic [dbpm_pkg::POS_OUT_W-1:0] close_pos;
	logic                           end_mark;

	modport source (output valid, output kind, output open_pos, output close_pos,
		output end_mark, input ready);
	modport sink (input valid, input kind, input open_pos, input close_pos,
		input end_mark, output ready);
endinterface

// File: rtl/core/dbpm_front.sv
`include "assert_macros.svh"

module dbpm_front #(
	parameter int MAX_LEN     = 1024,
	parameter int STACK_DEPTH = 256,
	parameter int PAIR_TYPES  = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dbpm_pkg::cfg_t  cfg,
	dbpm_char_if.sink       chars,
	input  logic            slot_ok,
	output logic            cmd_valid,
	output dbpm_pkg::entry_t cmd_entry
);
	import dbpm_pkg::*;

	localparam int NT     = (PAIR_TYPES < CHAR_SLOTS) ? PAIR_TYPES : CHAR_SLOTS;
	localparam int TYPE_W = (NT > 1) ? $clog2(NT) : 1;
	localparam int HGT_W  = $clog2(STACK_DEPTH + 1);
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int POS_W  = $clog2(MAX_LEN + 1);
	localparam int MEM_D  = (1 << TYPE_W) * (1 << SAW);

	function automatic logic in_set(logic [CFG_W-1:0] word, logic [SYM_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < CHAR_SLOTS; k++) begin
			if (word[SYM_W*k +: SYM_W] == c) hit = 1'b1;
		end
		return hit;
	endfunction

	logic [HGT_W-1:0]     hgt_q [NT];
	logic [HGT_W-1:0]     hgt_nx [NT];
	logic [POS_W-1:0]     pos_q;
	logic                 err_set_q;
	kind_t                err_kind_q;
	logic [POS_OUT_W-1:0] stack_mem [MEM_D];
	logic [POS_OUT_W-1:0] rd_s1;
	logic                 s1_valid_q;
	cmd_t                 cmd_s1;

	logic [TYPES_W-1:0] used;
	logic               open_hit, close_hit, is_break, is_unp;
	logic [TYPE_W-1:0]  to_idx, tc_idx;
	logic [HGT_W-1:0]   h_to, h_tc, h_tc_m1;
	logic               acc, do_push, do_pop, pos_inc, new_err, any_open;
	kind_t              new_kind, status;

	assign chars.ready = slot_ok;
	assign acc = chars.valid && chars.ready;

	assign used = (cfg.types_used > TYPES_W'(NT)) ? TYPES_W'(NT) : cfg.types_used;

	// Type lookup: scan downward so the lowest matching type index wins.
	always_comb begin
		open_hit  = 1'b0;
		close_hit = 1'b0;
		to_idx    = '0;
		tc_idx    = '0;
		for (int t = NT - 1; t >= 0; t--) begin
			if (TYPES_W'(t) < used && cfg.open_chars[SYM_W*t +: SYM_W] == chars.symbol) begin
				open_hit = 1'b1;
				to_idx   = TYPE_W'(t);
			end
			if (TYPES_W'(t) < used && cfg.close_chars[SYM_W*t +: SYM_W] == chars.symbol) begin
				close_hit = 1'b1;
				tc_idx    = TYPE_W'(t);
			end
		end
	end

	assign is_break = in_set(cfg.break_chars, chars.symbol);
	assign is_unp   = in_set(cfg.unpaired_chars, chars.symbol);
	assign h_to     = hgt_q[to_idx];
	assign h_tc     = hgt_q[tc_idx];
	assign h_tc_m1  = h_tc - HGT_W'(1);

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		pos_inc  = 1'b0;
		new_err  = 1'b0;
		new_kind = KIND_ILLEGAL;
		if (!err_set_q && !is_break) begin
			if (!open_hit && !close_hit && !is_unp) begin
				new_err = 1'b1;
			end else if (pos_q >= POS_W'(MAX_LEN)) begin
				new_err  = 1'b1;
				new_kind = KIND_OVERFLOW;
			end else if (open_hit) begin
				if (h_to >= HGT_W'(STACK_DEPTH)) begin
					new_err  = 1'b1;
					new_kind = KIND_OVERFLOW;
				end else begin
					do_push = 1'b1;
					pos_inc = 1'b1;
				end
			end else if (close_hit) begin
				if (h_tc == '0) begin
					new_err  = 1'b1;
					new_kind = KIND_UNMATCHED;
				end else begin
					do_pop  = 1'b1;
					pos_inc = 1'b1;
				end
			end else begin
				pos_inc = 1'b1;
			end
		end
	end

	always_comb begin
		any_open = 1'b0;
		for (int t = 0; t < NT; t++) begin
			hgt_nx[t] = hgt_q[t];
			if (do_push && to_idx == TYPE_W'(t)) hgt_nx[t] = hgt_q[t] + HGT_W'(1);
			if (do_pop && tc_idx == TYPE_W'(t)) hgt_nx[t] = h_tc_m1;
			if (hgt_nx[t] != '0) any_open = 1'b1;
		end
		if (err_set_q) status = err_kind_q;
		else if (new_err) status = new_kind;
		else if (any_open) status = KIND_UNCLOSED;
		else status = KIND_VALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) hgt_q[t] <= '0;
			pos_q      <= '0;
			err_set_q  <= 1'b0;
			err_kind_q <= KIND_ILLEGAL;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= acc && (do_pop || chars.last);
			if (acc) begin
				if (chars.last) begin
					for (int t = 0; t < NT; t++) hgt_q[t] <= '0;
					pos_q     <= '0;
					err_set_q <= 1'b0;
				end else begin
					for (int t = 0; t < NT; t++) hgt_q[t] <= hgt_nx[t];
					if (pos_inc) pos_q <= pos_q + POS_W'(1);
					if (new_err) begin
						err_set_q  <= 1'b1;
						err_kind_q <= new_kind;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1.has_pair   <= do_pop;
			cmd_s1.close_pos  <= POS_OUT_W'(pos_q);
			cmd_s1.has_status <= chars.last;
			cmd_s1.status     <= status;
		end
	end

	// Stack storage: one port, a push writes and a pop reads, never both.
	always_ff @(posedge clk) begin
		if (acc && do_push) stack_mem[{to_idx, h_to[SAW-1:0]}] <= POS_OUT_W'(pos_q);
		if (acc && do_pop) rd_s1 <= stack_mem[{tc_idx, h_tc_m1[SAW-1:0]}];
	end

	assign cmd_valid          = s1_valid_q;
	assign cmd_entry.cmd      = cmd_s1;
	assign cmd_entry.open_pos = rd_s1;

	`ASSERT_NEXT(a_pop_gives_pair, acc && do_pop, s1_valid_q && cmd_s1.has_pair,
		"pop did not produce a pair command")
	`ASSERT_NEXT(a_last_clears, acc && chars.last, pos_q == '0 && !err_set_q,
		"string state not cleared after last character")
	`ASSERT_NOW(a_one_stack_op, acc, !(do_push && do_pop),
		"push and pop in the same cycle")

endmodule

// File: rtl/core/dbpm_queue.sv
`include "assert_macros.svh"

module dbpm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dbpm_pkg::entry_t push_entry,
	output logic             slot_ok,
	dbpm_res_if.source       results
);
	import dbpm_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	entry_t           q_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pair_sent_q;

	entry_t       head;
	logic [CNT_W:0] occ;
	logic         pair_pending, take, pop;

	// One slot is held back for the command already in flight from the front.
	assign occ     = (CNT_W + 1)'(count_q) + (CNT_W + 1)'(push);
	assign slot_ok = occ < (CNT_W + 1)'(QDEPTH);

	assign head         = q_q[rd_ptr_q];
	assign pair_pending = head.cmd.has_pair && !pair_sent_q;

	assign results.valid     = count_q != '0;
	assign results.kind      = pair_pending ? KIND_PAIR : head.cmd.status;
	assign results.open_pos  = pair_pending ? head.open_pos : '0;
	assign results.close_pos = pair_pending ? head.cmd.close_pos : '0;
	assign results.end_mark  = !pair_pending;

	assign take = results.valid && results.ready;
	assign pop  = take && !(pair_pending && head.cmd.has_status);

	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			pair_sent_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
			if (pop) pair_sent_q <= 1'b0;
			else if (take) pair_sent_q <= 1'b1;
		end
	end

	`ASSERT_NOW(a_no_overrun, push, (count_q != CNT_W'(QDEPTH)) || pop,
		"command pushed into a full queue")
	`ASSERT_NEXT(a_stall_holds, results.valid && !results.ready,
		$stable(rd_ptr_q) && $stable(pair_sent_q), "stalled result moved on")

endmodule

// File: rtl/core/dot_bracket_pair_matcher.sv
// Dot-bracket pair matcher.
// Characters arrive on the chars channel (symbol, last); one is accepted per
// cycle while the internal result queue has room. Break characters are
// skipped, every other legal character takes the next position from zero.
// Each closing character that finds its partner yields a pair request on the
// results channel, and the character flagged last yields a status request
// (end_mark set) after any pair of its own; the string state is then cleared.
// The first character of a string that errs latches the status kind and the
// rest of the string is ignored until last.
// Each result command is registered in the front, then written to the queue.
// Throughput: one character per cycle while the queue has room, bounded by
// the single stack memory port (one push or one pop per character); a last
// character that also closes a pair yields two result requests.
// A four-entry queue separates the front from the result port, so a stall on
// results stops input only when that queue fills.
// Reset clears positions, stack heights, errors and the queue and loads the
// default symbol set; stack memory contents are not cleared, only popped
// entries are ever read. The user writes configuration through cfg_we,
// cfg_idx and cfg_data only while no string is in progress; not enforced.
module dot_bracket_pair_matcher #(
	parameter int MAX_LEN     = 1024,
	parameter int STACK_DEPTH = 256,
	parameter int PAIR_TYPES  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dbpm_char_if.sink                      chars,
	dbpm_res_if.source                     results,
	input  logic                           cfg_we,
	input  logic [dbpm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dbpm_pkg::CFG_W-1:0]     cfg_data
);
	import dbpm_pkg::*;

	// Default symbol set: "([{<", ")]}>", four types, "....", "&&&&".
	localparam logic [CFG_W-1:0] OPEN_RST     = 32'h3C7B5B28;
	localparam logic [CFG_W-1:0] CLOSE_RST    = 32'h3E7D5D29;
	localparam logic [TYPES_W-1:0] TYPES_RST  = 3'd4;
	localparam logic [CFG_W-1:0] UNPAIRED_RST = 32'h2E2E2E2E;
	localparam logic [CFG_W-1:0] BREAK_RST    = 32'h26262626;

	cfg_t   cfg_q;
	logic   cmd_valid;
	entry_t cmd_entry;
	logic   slot_ok;

	// Register file; writes to indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_chars     <= OPEN_RST;
			cfg_q.close_chars    <= CLOSE_RST;
			cfg_q.types_used     <= TYPES_RST;
			cfg_q.unpaired_chars <= UNPAIRED_RST;
			cfg_q.break_chars    <= BREAK_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OPEN: begin
					cfg_q.open_chars <= cfg_data;
				end
				CFG_CLOSE: begin
					cfg_q.close_chars <= cfg_data;
				end
				CFG_TYPES: begin
					cfg_q.types_used <= cfg_data[TYPES_W-1:0];
				end
				CFG_UNPAIRED: begin
					cfg_q.unpaired_chars <= cfg_data;
				end
				CFG_BREAK: begin
					cfg_q.break_chars <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Front: classifies characters, tracks stacks and issues result commands.
	dbpm_front #(
		.MAX_LEN    (MAX_LEN),
		.STACK_DEPTH(STACK_DEPTH),
		.PAIR_TYPES (PAIR_TYPES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.chars    (chars),
		.slot_ok  (slot_ok),
		.cmd_valid(cmd_valid),
		.cmd_entry(cmd_entry)
	);

	// Back: buffers commands and expands each into one or two result requests.
	dbpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_entry(cmd_entry),
		.slot_ok   (slot_ok),
		.results   (results)
	);

endmodule
